FILE: src/bitmap_first_fit_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap first-fit allocator
// Short forms for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BFFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared constants and types of the bitmap first-fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bffa_pkg;

  parameter int unsigned MemUnitsDefault = 1024;

  // The occupancy map is stored as words of this many units.
  parameter int unsigned WordBits    = 16;
  parameter int unsigned WordIdxBits = 4;

  parameter int unsigned OpBits    = 2;
  parameter int unsigned SizeBits  = 11;
  parameter int unsigned FloorBits = 10;
  parameter int unsigned StartBits = 10;

  typedef enum logic [OpBits-1:0] {
    OpAlloc = 2'd0,
    OpFree  = 2'd1,
    OpClear = 2'd2
  } op_e;

  // Result of evaluating one map word during the free-run search.
  typedef struct packed {
    logic                   found;
    logic [WordIdxBits-1:0] hit_bit;
    logic [SizeBits-1:0]    run_out;
  } scan_res_t;

endpackage

`default_nettype wire

FILE: src/bffa_ram.sv
// ----------------------------------------------------------------------------
// bffa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_ram #(
  parameter int unsigned DATA_W = 16,
  parameter int unsigned DEPTH  = 64,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/bffa_word_scan.sv
// ----------------------------------------------------------------------------
// bffa_word_scan
// Finds where a free run of the requested length first completes in one word.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_word_scan import bffa_pkg::*; (
  input  logic [WordBits-1:0] occ_i,
  input  logic [SizeBits-1:0] run_in_i,
  input  logic [SizeBits-1:0] size_i,
  output scan_res_t           res_o
);

  // Each bit position computes the free run ending there on its own: either the
  // whole word so far is free and the incoming run continues, or the run starts
  // after the highest used bit at or below it.
  always_comb begin
    logic [SizeBits:0]      run_v [WordBits];
    logic [WordBits-1:0]    hit;
    logic [WordIdxBits-1:0] last;
    logic                   seen;
    hit           = '0;
    res_o.hit_bit = '0;
    for (int i = 0; i < WordBits; i++) begin
      last = '0;
      seen = 1'b0;
      for (int j = 0; j <= i; j++) begin
        if (occ_i[j]) begin
          last = WordIdxBits'(j);
          seen = 1'b1;
        end
      end
      if (!seen) begin
        run_v[i] = {1'b0, run_in_i} + (SizeBits + 1)'(i + 1);
      end else begin
        run_v[i] = (SizeBits + 1)'(i) - (SizeBits + 1)'(last);
      end
      hit[i] = (run_v[i] >= {1'b0, size_i});
    end
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (hit[i]) begin
        res_o.hit_bit = WordIdxBits'(i);
      end
    end
    res_o.found = |hit;
    if (run_v[WordBits-1][SizeBits]) begin
      res_o.run_out = '1;
    end else begin
      res_o.run_out = run_v[WordBits-1][SizeBits-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: src/bitmap_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator
// Contiguous first-fit allocator over a one-bit-per-unit occupancy map.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Beat contents
//   request   in         in_valid_i/in_ready_o   op, block_size, floor_unit, start_unit
//   response  out        out_valid_o/out_ready_i granted, block_start
//
// Storage: the map lives in a RAM of W = ceil(MEM_UNITS/16) words, one word
// read per cycle. An allocate reads from the floor word to the word where the
// run completes, then rereads and marks the words the run covers; a refused
// allocate that scans to the end reads every word from the floor word on; a
// free rewrites the words it covers; a clear writes zero to all W words.
// After reset a clearing pass writes zero to all W words; no request is taken
// during that pass.
// One request is in flight at a time; the response sits in an output register,
// so a new request is taken while an earlier response still waits.
//
`default_nettype none

`include "bitmap_first_fit_allocator_assert.svh"

module bitmap_first_fit_allocator import bffa_pkg::*; #(
  parameter int unsigned MEM_UNITS = MemUnitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OpBits-1:0]    op_i,
  input  logic [SizeBits-1:0]  block_size_i,
  input  logic [FloorBits-1:0] floor_unit_i,
  input  logic [StartBits-1:0] start_unit_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 granted_o,
  output logic [StartBits-1:0] block_start_o
);

  // Map geometry. Units past MEM_UNITS in the last word are never allocated.
  localparam int unsigned NumWords = (MEM_UNITS + WordBits - 1) / WordBits;
  localparam int unsigned WAW      = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int unsigned PW       = WAW + WordIdxBits;
  // Wide enough for any unit position and for start + size of a free request.
  localparam int unsigned EW       = ((PW > SizeBits + 1) ? PW : SizeBits + 1) + 1;
  localparam int unsigned TW       = EW - WordIdxBits;

  localparam logic [WAW-1:0] LastWord  = WAW'(NumWords - 1);
  localparam logic [EW-1:0]  MemUnitsE = EW'(MEM_UNITS);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StClear = 5'b00010,
    StScan  = 5'b00100,
    StFill  = 5'b01000,
    StDone  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [SizeBits-1:0]  size_q, size_d;
  logic [FloorBits-1:0] floor_q, floor_d;
  logic [EW-1:0]        lo_q, lo_d;
  logic [EW-1:0]        hi_q, hi_d;
  logic [WAW-1:0]       last_w_q, last_w_d;
  logic [WAW-1:0]       rd_addr_q, rd_addr_d;
  logic                 issue_q, issue_d;
  logic                 dv_q, dv_d;
  logic [WAW-1:0]       data_w_q, data_w_d;
  logic [SizeBits-1:0]  run_q, run_d;
  logic                 fill_set_q, fill_set_d;
  logic                 clr_resp_q, clr_resp_d;
  logic                 res_granted_q, res_granted_d;
  logic [StartBits-1:0] res_start_q, res_start_d;
  logic                 out_valid_q, out_valid_d;
  logic                 granted_q, granted_d;
  logic [StartBits-1:0] block_start_q, block_start_d;

  logic                 ram_we;
  logic [WAW-1:0]       ram_waddr;
  logic [WordBits-1:0]  ram_wdata;
  logic                 ram_re;
  logic [WAW-1:0]       ram_raddr;
  logic [WordBits-1:0]  ram_rdata;

  logic [WordBits-1:0]  occ_masked;
  logic [WordBits-1:0]  fill_mask;
  logic [WordBits-1:0]  fill_word;
  scan_res_t            scan_res;
  logic [EW-1:0]        found_start;
  logic [EW-1:0]        found_end;
  logic [EW-1:0]        floor_e;
  logic [EW-1:0]        start_e;
  logic [EW-1:0]        size_e;
  logic [EW-1:0]        free_end;
  logic                 alloc_reject;
  logic                 free_skip;

  // Last word touched by a range that ends just before hi, clipped to the map.
  function automatic logic [WAW-1:0] last_word_of(input logic [EW-1:0] hi);
    logic [EW-1:0] tail;
    logic [TW-1:0] w;
    tail = hi - EW'(1);
    w    = tail[EW-1:WordIdxBits];
    if (w > TW'(LastWord)) begin
      return LastWord;
    end
    return w[WAW-1:0];
  endfunction

  bffa_ram #(
    .DATA_W (WordBits),
    .DEPTH  (NumWords)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Units below the floor and past the end of memory look occupied to the
  // search, so a run can never start below the floor or run off the map.
  always_comb begin
    logic [EW-1:0] pos;
    for (int b = 0; b < WordBits; b++) begin
      pos           = EW'({data_w_q, WordIdxBits'(b)});
      occ_masked[b] = ram_rdata[b] | (pos < EW'(floor_q)) | (pos >= MemUnitsE);
      fill_mask[b]  = (pos >= lo_q) && (pos < hi_q);
    end
  end

  assign fill_word = fill_set_q ? (ram_rdata | fill_mask) : (ram_rdata & ~fill_mask);

  bffa_word_scan u_word_scan (
    .occ_i    (occ_masked),
    .run_in_i (run_q),
    .size_i   (size_q),
    .res_o    (scan_res)
  );

  // The run completes at the hit bit, so it began size - 1 units earlier.
  assign found_start = EW'({data_w_q, scan_res.hit_bit}) + EW'(1) - EW'(size_q);
  assign found_end   = found_start + EW'(size_q);

  assign floor_e  = EW'(floor_unit_i);
  assign start_e  = EW'(start_unit_i);
  assign size_e   = EW'(block_size_i);
  assign free_end = start_e + size_e;

  assign alloc_reject = (block_size_i == '0) || (size_e > MemUnitsE) || (floor_e >= MemUnitsE);
  assign free_skip    = (block_size_i == '0) || (start_e >= MemUnitsE);

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d       = state_q;
    size_d        = size_q;
    floor_d       = floor_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    last_w_d      = last_w_q;
    rd_addr_d     = rd_addr_q;
    issue_d       = issue_q;
    dv_d          = dv_q;
    data_w_d      = data_w_q;
    run_d         = run_q;
    fill_set_d    = fill_set_q;
    clr_resp_d    = clr_resp_q;
    res_granted_d = res_granted_q;
    res_start_d   = res_start_q;
    out_valid_d   = out_valid_q;
    granted_d     = granted_q;
    block_start_d = block_start_q;

    ram_we    = 1'b0;
    ram_waddr = data_w_q;
    ram_wdata = fill_word;
    ram_re    = 1'b0;
    ram_raddr = rd_addr_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          size_d  = block_size_i;
          floor_d = floor_unit_i;
          case (op_i)
            OpAlloc: begin
              if (alloc_reject) begin
                res_granted_d = 1'b0;
                res_start_d   = '0;
                state_d       = StDone;
              end else begin
                run_d     = '0;
                rd_addr_d = floor_e[PW-1:WordIdxBits];
                issue_d   = 1'b1;
                dv_d      = 1'b0;
                state_d   = StScan;
              end
            end
            OpFree: begin
              lo_d          = start_e;
              hi_d          = free_end;
              last_w_d      = last_word_of(free_end);
              fill_set_d    = 1'b0;
              res_granted_d = 1'b1;
              res_start_d   = '0;
              if (free_skip) begin
                state_d = StDone;
              end else begin
                rd_addr_d = start_e[PW-1:WordIdxBits];
                issue_d   = 1'b1;
                dv_d      = 1'b0;
                state_d   = StFill;
              end
            end
            OpClear: begin
              rd_addr_d  = '0;
              clr_resp_d = 1'b1;
              state_d    = StClear;
            end
            default: begin
              res_granted_d = 1'b0;
              res_start_d   = '0;
              state_d       = StDone;
            end
          endcase
        end
      end

      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = rd_addr_q;
        ram_wdata = '0;
        if (rd_addr_q == LastWord) begin
          res_granted_d = 1'b1;
          res_start_d   = '0;
          clr_resp_d    = 1'b0;
          state_d       = clr_resp_q ? StDone : StIdle;
        end else begin
          rd_addr_d = rd_addr_q + WAW'(1);
        end
      end

      StScan: begin
        ram_re   = issue_q;
        dv_d     = issue_q;
        data_w_d = rd_addr_q;
        if (issue_q) begin
          rd_addr_d = rd_addr_q + WAW'(1);
          if (rd_addr_q == LastWord) begin
            issue_d = 1'b0;
          end
        end
        if (dv_q) begin
          if (scan_res.found) begin
            // Run found: restart the read stream at its first word to mark it.
            lo_d          = found_start;
            hi_d          = found_end;
            last_w_d      = last_word_of(found_end);
            rd_addr_d     = found_start[PW-1:WordIdxBits];
            issue_d       = 1'b1;
            dv_d          = 1'b0;
            fill_set_d    = 1'b1;
            res_granted_d = 1'b1;
            res_start_d   = found_start[StartBits-1:0];
            state_d       = StFill;
          end else begin
            run_d = scan_res.run_out;
            if (data_w_q == LastWord) begin
              issue_d       = 1'b0;
              dv_d          = 1'b0;
              res_granted_d = 1'b0;
              res_start_d   = '0;
              state_d       = StDone;
            end
          end
        end
      end

      StFill: begin
        // Word w is written back while word w+1 is read, so the two ports
        // never address the same entry.
        ram_re   = issue_q;
        ram_we   = dv_q;
        dv_d     = issue_q;
        data_w_d = rd_addr_q;
        if (issue_q) begin
          rd_addr_d = rd_addr_q + WAW'(1);
          if (rd_addr_q == last_w_q) begin
            issue_d = 1'b0;
          end
        end
        if (dv_q && (data_w_q == last_w_q)) begin
          issue_d = 1'b0;
          dv_d    = 1'b0;
          state_d = StDone;
        end
      end

      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          granted_d     = res_granted_q;
          block_start_d = res_start_q;
          state_d       = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state. Reset starts the clearing pass over the map.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      rd_addr_q   <= '0;
      issue_q     <= 1'b0;
      dv_q        <= 1'b0;
      clr_resp_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_addr_q   <= rd_addr_d;
      issue_q     <= issue_d;
      dv_q        <= dv_d;
      clr_resp_q  <= clr_resp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    size_q        <= size_d;
    floor_q       <= floor_d;
    lo_q          <= lo_d;
    hi_q          <= hi_d;
    last_w_q      <= last_w_d;
    data_w_q      <= data_w_d;
    run_q         <= run_d;
    fill_set_q    <= fill_set_d;
    res_granted_q <= res_granted_d;
    res_start_q   <= res_start_d;
    granted_q     <= granted_d;
    block_start_q <= block_start_d;
  end

  assign out_valid_o   = out_valid_q;
  assign granted_o     = granted_q;
  assign block_start_o = block_start_q;

  // The write-back and the read stream must never touch the same word.
  `BFFA_ASSERT_IMP(a_no_rw_collision, ram_we && ram_re, ram_waddr != ram_raddr, "map read and write hit the same word")
  // A refused request always reports start zero.
  `BFFA_ASSERT_IMP(a_fail_start_zero, out_valid_o && !granted_o, block_start_o == '0, "refused beat carries a nonzero start")
  // An accepted request always leaves the idle state.
  `BFFA_ASSERT_NXT(a_accept_leaves_idle, in_valid_i && in_ready_o, state_q != StIdle, "request accepted but block stayed idle")
  // Marking or freeing never writes past the last word of its range.
  `BFFA_ASSERT_IMP(a_fill_in_range, (state_q == StFill) && dv_q, data_w_q <= last_w_q, "range write ran past its last word")

endmodule

`default_nettype wire

FILE: sim/bffa_checker.sv
// ----------------------------------------------------------------------------
// bffa_checker
// Watches both channels of the allocator, keeps its own occupancy map and
// compares every response beat with the grant expected for the oldest request.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_checker import bffa_pkg::*; #(
  parameter int unsigned MemUnits = MemUnitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [OpBits-1:0]    op_i,
  input  logic [SizeBits-1:0]  block_size_i,
  input  logic [FloorBits-1:0] floor_unit_i,
  input  logic [StartBits-1:0] start_unit_i,

  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 granted_i,
  input  logic [StartBits-1:0] block_start_i,

  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic                 granted;
    logic [StartBits-1:0] block_start;
  } grant_t;

  bit [MemUnits-1:0] unit_used;
  grant_t            expected_grants[$];
  int unsigned       mismatches = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Applies one request to the local map and returns the grant it yields.
  function automatic grant_t serve_request(input logic [OpBits-1:0]    op,
                                           input logic [SizeBits-1:0]  size,
                                           input logic [FloorBits-1:0] floor_u,
                                           input logic [StartBits-1:0] start_u);
    grant_t      res;
    int unsigned run_len;
    int unsigned first;
    int unsigned u;
    res     = '0;
    run_len = 0;
    first   = 0;
    case (op)
      OpAlloc: begin
        if (size != 0 && size <= MemUnits && floor_u < MemUnits) begin
          for (u = 32'(floor_u); u < MemUnits && !res.granted; u++) begin
            if (unit_used[u]) begin
              run_len = 0;
            end else begin
              run_len++;
              if (run_len == size) begin
                first       = u + 1 - 32'(size);
                res.granted = 1'b1;
              end
            end
          end
          if (res.granted) begin
            for (u = first; u < first + 32'(size); u++) unit_used[u] = 1'b1;
            res.block_start = first[StartBits-1:0];
          end
        end
      end
      OpFree: begin
        for (u = 32'(start_u); u < 32'(start_u) + 32'(size) && u < MemUnits; u++)
          unit_used[u] = 1'b0;
        res.granted = 1'b1;
      end
      OpClear: begin
        unit_used   = '0;
        res.granted = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t seen;
    grant_t want;
    if (!rst_ni) begin
      unit_used = '0;
      expected_grants.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // A response leaving in the same cycle as a request arrives belongs to
      // an earlier request, so it is checked before the new one is queued.
      if (out_valid_i && out_ready_i) begin
        seen.granted     = granted_i;
        seen.block_start = block_start_i;
        if (expected_grants.size() == 0) begin
          report_mismatch("response with nothing outstanding", 32'(seen.granted), 0);
        end else begin
          want = expected_grants.pop_front();
          if (seen.granted !== want.granted)
            report_mismatch("granted", 32'(seen.granted), 32'(want.granted));
          if (seen.block_start !== want.block_start)
            report_mismatch("block_start", 32'(seen.block_start),
                            32'(want.block_start));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_grants.push_back(serve_request(op_i, block_size_i, floor_unit_i,
                                                start_unit_i));
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_grants.size();
    end
  end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, free, clear and unknown-code requests into the first-fit
// allocator with random gaps and back-pressure; a checker beside the block
// predicts and compares every response beat, and this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import bffa_pkg::*;

  localparam int unsigned MemUnits  = MemUnitsDefault;
  localparam int unsigned ClkPeriod = 10;
  localparam int unsigned MapWords  = (MemUnits + WordBits - 1) / WordBits;

  // The package has no name for op code 3; the block must answer it with a
  // refusal and leave the map alone.
  localparam logic [OpBits-1:0] OpUnknown = 2'd3;

  localparam int unsigned RandomRequests = 530;
  localparam int unsigned PauseAtRequest = 300;  // sender waits for a quiet block here
  localparam int unsigned HoldAtBeat     = 120;  // receiver starts its long hold here
  localparam int unsigned HoldCycles     = 300;
  // Longest request is an allocate that scans the map about twice.
  localparam int unsigned DrainCycles    = 2 * MapWords + 8;
  localparam int unsigned CycleLimit     = 400000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [OpBits-1:0]    op_i;
  logic [SizeBits-1:0]  block_size_i;
  logic [FloorBits-1:0] floor_unit_i;
  logic [StartBits-1:0] start_unit_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 granted_o;
  logic [StartBits-1:0] block_start_o;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned cycle_count = 0;
  bit          sender_calm = 1'b0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  bitmap_first_fit_allocator #(
    .MEM_UNITS(MemUnits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .block_size_i (block_size_i),
    .floor_unit_i (floor_unit_i),
    .start_unit_i (start_unit_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .granted_o    (granted_o),
    .block_start_o(block_start_o)
  );

  bffa_checker #(
    .MemUnits(MemUnits)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .op_i         (op_i),
    .block_size_i (block_size_i),
    .floor_unit_i (floor_unit_i),
    .start_unit_i (start_unit_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .granted_i    (granted_o),
    .block_start_i(block_start_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  // Offers one request beat. It is entered at a falling edge and returns at
  // the falling edge after the beat was taken. When no gap is drawn, valid
  // stays high and only the payload changes, so valid is never lowered and
  // raised again within one time step.
  task automatic send_request(input logic [OpBits-1:0]    op,
                              input logic [SizeBits-1:0]  size,
                              input logic [FloorBits-1:0] floor_u,
                              input logic [StartBits-1:0] start_u);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    block_size_i <= size;
    floor_unit_i <= floor_u;
    start_unit_i <= start_u;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drops valid and waits until every outstanding request has been answered.
  // It always ends on a later falling edge so that the next request does not
  // assign valid in the same time step.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Request side: directed corner cases first, then a long random mix.
  initial begin : request_source
    int unsigned          n;
    int unsigned          pick;
    logic [OpBits-1:0]    op;
    logic [SizeBits-1:0]  size;
    logic [FloorBits-1:0] floor_u;
    logic [StartBits-1:0] start_u;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    op_i         = OpAlloc;
    block_size_i = '0;
    floor_unit_i = '0;
    start_unit_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // The block runs its clearing pass now; the first beat simply waits for
    // in_ready.

    // Smallest and a word-sized allocate on an empty map.
    send_request(OpAlloc, 11'd1, 10'd0, 10'd0);
    send_request(OpAlloc, 11'd16, 10'd0, 10'd0);
    // Whole memory no longer fits; zero size and oversize never fit.
    send_request(OpAlloc, 11'd1024, 10'd0, 10'd0);
    send_request(OpAlloc, 11'd0, 10'd0, 10'd0);
    send_request(OpAlloc, 11'd2047, 10'd0, 10'd0);
    send_request(OpAlloc, 11'd1025, 10'd0, 10'd0);
    // An unknown code with every field at its top changes nothing.
    send_request(OpUnknown, 11'd2047, 10'd1023, 10'd1023);
    // Punch a hole at unit 0 and refill it.
    send_request(OpFree, 11'd1, 10'd0, 10'd0);
    send_request(OpAlloc, 11'd1, 10'd0, 10'd0);
    // Runs that would cross the end of memory are refused; the last unit fits.
    send_request(OpAlloc, 11'd5, 10'd1023, 10'd0);
    send_request(OpAlloc, 11'd1, 10'd1023, 10'd0);
    // Free past the end and zero-size free are both granted.
    send_request(OpFree, 11'd2047, 10'd0, 10'd1023);
    send_request(OpFree, 11'd0, 10'd0, 10'd5);
    send_request(OpClear, 11'd0, 10'd0, 10'd0);
    // Fill the whole map, find it full, then free the upper half and refill it.
    send_request(OpAlloc, 11'd1024, 10'd0, 10'd0);
    send_request(OpAlloc, 11'd1, 10'd0, 10'd0);
    send_request(OpFree, 11'd1024, 10'd0, 10'd512);
    send_request(OpAlloc, 11'd512, 10'd0, 10'd0);
    send_request(OpClear, 11'd0, 10'd0, 10'd0);
    // Alternating bit patterns in size and floor.
    send_request(OpAlloc, 11'h2AA, 10'h155, 10'h2AA);
    send_request(OpAlloc, 11'h155, 10'h2AA, 10'h155);
    send_request(OpAlloc, 11'h155, 10'd0, 10'd0);
    send_request(OpFree, 11'h7FF, 10'd0, 10'h3FF);
    send_request(OpClear, 11'd0, 10'd0, 10'd0);
    settle();

    // Random part: mostly small allocations from low floors and frees over the
    // same area, so the map fragments and allocations start failing; clears
    // reset it now and then. A few requests use full-range sizes and floors.
    for (n = 0; n < RandomRequests; n++) begin
      if (n % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      if (n == PauseAtRequest) settle();

      pick = $urandom_range(0, 99);
      if (pick < 70)      size = SizeBits'($urandom_range(1, 32));
      else if (pick < 90) size = SizeBits'($urandom_range(1, 256));
      else if (pick < 97) size = SizeBits'($urandom_range(257, 1024));
      else if (pick < 98) size = 11'd0;
      else                size = SizeBits'($urandom_range(1025, 2047));

      floor_u = FloorBits'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, 127));
      start_u = StartBits'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, 511));

      pick = $urandom_range(0, 99);
      if (pick < 55)      op = OpAlloc;
      else if (pick < 90) op = OpFree;
      else if (pick < 96) op = OpClear;
      else                op = OpUnknown;

      send_request(op, size, floor_u, start_u);
    end

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Response side: random stalls before each beat, calm stretches now and
  // then, and one long hold that backs the block up into its request port.
  initial begin : response_sink
    int unsigned stall;
    int unsigned delivered;
    bit          calm;
    out_ready_i = 1'b0;
    delivered   = 0;
    calm        = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (delivered % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
      delivered++;
      if (delivered == HoldAtBeat) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
    end
  end

  // Watchdog: a hung handshake or a missing response ends the run here.
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+src
src/bffa_pkg.sv
src/bffa_ram.sv
src/bffa_word_scan.sv
src/bitmap_first_fit_allocator.sv
sim/bffa_checker.sv
sim/testbench.sv
